@@ sv/ycc_pkg.sv @@
// Shared constants, types and coefficients of the RGB to YCbCr 4:2:0 converter.
`timescale 1ns / 1ps
`default_nettype none

package ycc_pkg;

   // Pixel and accumulation widths
   localparam int PIX_W  = 8;
   localparam int SUM2_W = PIX_W + 1;   // sum of a horizontal pair
   localparam int SUM4_W = PIX_W + 2;   // sum of a 2x2 block

   // Line geometry
   localparam int MAX_WIDTH  = 2048;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int LW_W       = 12;
   localparam int WIDTH_W    = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
   localparam int WIDTH_CAP  = (MAX_WIDTH / 2) * 2;
   localparam logic [LW_W-1:0] LW_RESET = LW_W'(640);

   // Configuration port
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;
   localparam logic [CSR_AW-1:0] ADDR_LINE_WIDTH = CSR_AW'(0);

   // Fixed-point coefficients, 16 fraction bits
   localparam int FRAC_BITS     = 16;
   localparam int Y_R_COEF      = 16828;
   localparam int Y_G_COEF      = 33038;
   localparam int Y_B_COEF      = 6416;
   localparam int CB_R_COEF     = 2428;   // subtracted
   localparam int CB_G_COEF     = 4768;   // subtracted
   localparam int CB_B_COEF     = 7196;
   localparam int CR_R_COEF     = 7196;
   localparam int CR_G_COEF     = 6026;   // subtracted
   localparam int CR_B_COEF     = 1170;   // subtracted
   localparam int LUMA_OFFSET   = 16;
   localparam int CHROMA_OFFSET = 128;

   // Product and sum widths
   localparam int YPROD_W = 24;   // luma terms and their sum
   localparam int CPROD_W = 23;   // one chroma term on a block sum
   localparam int CSUM_W  = 25;   // signed chroma sum, two's complement

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   // One line store entry: the pair sums of an even row
   typedef struct packed {
      logic [SUM2_W-1:0] blue_sum;
      logic [SUM2_W-1:0] green_sum;
      logic [SUM2_W-1:0] red_sum;
   } pair_sum_type;

   localparam int PAIR_W = $bits(pair_sum_type);

   // Front stage register contents
   typedef struct packed {
      pixel_type    pixel;
      pair_sum_type pair;
      logic         chroma;
   } stage1_type;

   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic             chroma_valid;
      logic [PIX_W-1:0] blue_diff;
      logic [PIX_W-1:0] red_diff;
   } result_type;

endpackage

`default_nettype wire

@@ sv/ycc_if.sv @@
// Request and response channel interfaces of the converter.
`timescale 1ns / 1ps
`default_nettype none

interface ycc_req_if;
   logic                       valid;
   logic                       ready;
   logic [ycc_pkg::PIX_W-1:0]  red;
   logic [ycc_pkg::PIX_W-1:0]  green;
   logic [ycc_pkg::PIX_W-1:0]  blue;
   logic                       frame_start;

   modport source (output valid, red, green, blue, frame_start, input ready);
   modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface ycc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [ycc_pkg::PIX_W-1:0]  luma;
   logic                       chroma_valid;
   logic [ycc_pkg::PIX_W-1:0]  blue_diff;
   logic [ycc_pkg::PIX_W-1:0]  red_diff;

   modport source (output valid, luma, chroma_valid, blue_diff, red_diff, input ready);
   modport sink   (input valid, luma, chroma_valid, blue_diff, red_diff, output ready);
endinterface

`default_nettype wire

@@ sv/rgb_to_ycbcr420_converter.sv @@
// Top level of the RGB to studio-range YCbCr 4:2:0 converter.
//
// Pixels enter on req_bus in raster order, one request per pixel, with
// frame_start high on the first pixel of each frame. Every request yields one
// response on rsp_bus carrying the pixel's luma; the bottom-right pixel of each
// 2x2 block also carries the block's Cb and Cr with chroma_valid high.
// Both channels use valid/ready; a request or response moves when both are high.
// A request passes through the front register (with the line store read), then
// the result register fed by single-pass arithmetic.
// Throughput is one pixel per clock while rsp_bus does not stall, set by the
// line store port and the one-register arithmetic path.
// When rsp_bus stalls, the front register still fills if empty and req_bus
// drops ready only once both registers hold pixels; nothing is lost.
// The line width register sits at byte address 0 of the APB port (reset 640).
// Write it only while the converter is idle.
// Synchronous reset empties the pipeline, clears column and row position and
// the held pixel. The line store is not cleared: every odd row reads entries
// the even row above it wrote.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_ycbcr420_converter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ycc_req_if.sink                             req_bus,
   ycc_rsp_if.source                           rsp_bus,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [ycc_pkg::CSR_AW-1:0]     paddr,
   input  wire logic [ycc_pkg::CSR_DW-1:0]     pwdata,
   output      logic [ycc_pkg::CSR_DW-1:0]     prdata,
   output      logic                           pready
);

   logic [ycc_pkg::WIDTH_W-1:0] width;
   logic                        s2_free;
   logic                        s1_valid;
   ycc_pkg::stage1_type         s1_data;
   ycc_pkg::pair_sum_type       above;

   ycc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .width   (width)
   );

   ycc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .width    (width),
      .s2_free  (s2_free),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .above    (above)
   );

   ycc_math u_math (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .above    (above),
      .s2_free  (s2_free),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

@@ sv/ycc_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module ycc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/ycc_csr.sv @@
// Configuration register block: line width register and its clamped form.
`timescale 1ns / 1ps
`default_nettype none

module ycc_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [ycc_pkg::CSR_AW-1:0]         paddr,
   input  wire logic [ycc_pkg::CSR_DW-1:0]         pwdata,
   output      logic [ycc_pkg::CSR_DW-1:0]         prdata,
   output      logic                               pready,
   output      logic [ycc_pkg::WIDTH_W-1:0]        width
);

   localparam logic [ycc_pkg::WIDTH_W-1:0] WIDTH_MIN = ycc_pkg::WIDTH_W'(2);
   localparam logic [ycc_pkg::WIDTH_W-1:0] WIDTH_MAX =
      ycc_pkg::WIDTH_W'(ycc_pkg::WIDTH_CAP);

   logic [ycc_pkg::LW_W-1:0]    line_width_ff;
   logic [ycc_pkg::LW_W-1:0]    line_width_in;
   logic                        wr_hit;
   logic [ycc_pkg::WIDTH_W-1:0] width_even;

   // Write the register on the access phase of a write
   assign wr_hit = psel && penable && pwrite && (paddr == ycc_pkg::ADDR_LINE_WIDTH);

   always_comb begin
      line_width_in = line_width_ff;
      if (wr_hit) begin
         line_width_in = pwdata[ycc_pkg::LW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= ycc_pkg::LW_RESET;
      end else begin
         line_width_ff <= line_width_in;
      end
   end

   assign pready = 1'b1;

   // Read back
   always_comb begin
      prdata = '0;
      if (paddr == ycc_pkg::ADDR_LINE_WIDTH) begin
         prdata = ycc_pkg::CSR_DW'(line_width_ff);
      end
   end

   // Drop bit 0, then clamp to the supported range
   always_comb begin
      width_even = ycc_pkg::WIDTH_W'({line_width_ff[ycc_pkg::LW_W-1:1], 1'b0});
      if (width_even < WIDTH_MIN) begin
         width = WIDTH_MIN;
      end else if (width_even > WIDTH_MAX) begin
         width = WIDTH_MAX;
      end else begin
         width = width_even;
      end
   end

endmodule

`default_nettype wire

@@ sv/ycc_front.sv @@
// Front stage: column and row tracking, pair sums, line store and input register.
`timescale 1ns / 1ps
`default_nettype none

module ycc_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ycc_req_if.sink                            req_bus,
   input  wire logic [ycc_pkg::WIDTH_W-1:0]   width,
   input  wire logic                          s2_free,
   output      logic                          s1_valid,
   output      ycc_pkg::stage1_type           s1_data,
   output      ycc_pkg::pair_sum_type         above
);

   logic [ycc_pkg::COL_W-1:0]   col_ff;
   logic [ycc_pkg::COL_W-1:0]   col_in;
   logic                        odd_ff;
   logic                        odd_in;
   ycc_pkg::pixel_type          held_ff;
   ycc_pkg::pixel_type          held_in;
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   ycc_pkg::stage1_type         s1_ff;
   ycc_pkg::stage1_type         s1_in;

   logic                        accept;
   logic [ycc_pkg::COL_W-1:0]   col_cur;
   logic                        odd_cur;
   logic                        row_end;
   ycc_pkg::pixel_type          pixel;
   ycc_pkg::pair_sum_type       pair;
   logic                        wr_en;
   logic                        rd_en;
   logic [ycc_pkg::LINE_AW-1:0] pair_idx;
   logic [ycc_pkg::PAIR_W-1:0]  rd_word;

   // Take a request whenever the front register is empty or moving on
   assign req_bus.ready = !s1_valid_ff || s2_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign pixel.red   = req_bus.red;
   assign pixel.green = req_bus.green;
   assign pixel.blue  = req_bus.blue;

   // Position of this pixel; frame start restarts at the top-left
   assign col_cur = req_bus.frame_start ? '0 : col_ff;
   assign odd_cur = req_bus.frame_start ? 1'b0 : odd_ff;
   assign row_end = (ycc_pkg::WIDTH_W'(col_cur) + ycc_pkg::WIDTH_W'(1)) >= width;

   // Horizontal pair sums with the held even-column pixel
   assign pair.red_sum   = ycc_pkg::SUM2_W'(held_ff.red)   + ycc_pkg::SUM2_W'(pixel.red);
   assign pair.green_sum = ycc_pkg::SUM2_W'(held_ff.green) + ycc_pkg::SUM2_W'(pixel.green);
   assign pair.blue_sum  = ycc_pkg::SUM2_W'(held_ff.blue)  + ycc_pkg::SUM2_W'(pixel.blue);

   // Even rows store pair sums, odd rows read them back
   assign pair_idx = ycc_pkg::LINE_AW'(col_cur >> 1);
   assign wr_en    = accept && col_cur[0] && !odd_cur;
   assign rd_en    = accept && col_cur[0] && odd_cur;

   ycc_ram #(
      .WIDTH (ycc_pkg::PAIR_W),
      .DEPTH (ycc_pkg::LINE_DEPTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pair_idx),
      .wr_data (pair),
      .rd_en   (rd_en),
      .rd_addr (pair_idx),
      .rd_data (rd_word)
   );

   assign above = rd_word;

   // Advance position, hold the even pixel, load the front register
   always_comb begin
      col_in      = col_ff;
      odd_in      = odd_ff;
      held_in     = held_ff;
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      if (s2_free) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         col_in        = row_end ? '0 : col_cur + ycc_pkg::COL_W'(1);
         odd_in        = odd_cur ^ row_end;
         if (!col_cur[0]) begin
            held_in = pixel;
         end
         s1_in.pixel   = pixel;
         s1_in.pair    = pair;
         s1_in.chroma  = col_cur[0] && odd_cur;
         s1_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         odd_ff      <= 1'b0;
         held_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         odd_ff      <= odd_in;
         held_ff     <= held_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_ff;

   // The line store never sees a read and a write together
   assert property (@(posedge clock) disable iff (reset) !(wr_en && rd_en))
      else $error("line store read and write in one cycle");

   // A row end restarts the column count
   assert property (@(posedge clock) disable iff (reset) (accept && row_end) |=> (col_ff == '0))
      else $error("column count not cleared at row end");

   // An even-column pixel is held for the pair sum
   assert property (@(posedge clock) disable iff (reset)
      (accept && !col_cur[0]) |=> (held_ff == $past(pixel)))
      else $error("even pixel not held");

endmodule

`default_nettype wire

@@ sv/ycc_math.sv @@
// Arithmetic stage: coefficient products, sums, offsets and the result register.
`timescale 1ns / 1ps
`default_nettype none

module ycc_math (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   s1_valid,
   input  wire ycc_pkg::stage1_type    s1_data,
   input  wire ycc_pkg::pair_sum_type  above,
   output      logic                   s2_free,
   ycc_rsp_if.source                   rsp_bus
);

   logic                        out_valid_ff;
   logic                        out_valid_in;
   ycc_pkg::result_type         out_ff;
   ycc_pkg::result_type         out_in;

   logic [ycc_pkg::SUM4_W-1:0]  r4;
   logic [ycc_pkg::SUM4_W-1:0]  g4;
   logic [ycc_pkg::SUM4_W-1:0]  b4;
   logic [ycc_pkg::YPROD_W-1:0] y_r;
   logic [ycc_pkg::YPROD_W-1:0] y_g;
   logic [ycc_pkg::YPROD_W-1:0] y_b;
   logic [ycc_pkg::CPROD_W-1:0] cb_r;
   logic [ycc_pkg::CPROD_W-1:0] cb_g;
   logic [ycc_pkg::CPROD_W-1:0] cb_b;
   logic [ycc_pkg::CPROD_W-1:0] cr_r;
   logic [ycc_pkg::CPROD_W-1:0] cr_g;
   logic [ycc_pkg::CPROD_W-1:0] cr_b;
   logic [ycc_pkg::YPROD_W-1:0] luma_sum;
   logic [ycc_pkg::CSUM_W-1:0]  cb_sum;
   logic [ycc_pkg::CSUM_W-1:0]  cr_sum;

   // The result register takes a new request when empty or being read
   assign s2_free = !out_valid_ff || rsp_bus.ready;

   // Block sums: this pair plus the pair above
   assign r4 = ycc_pkg::SUM4_W'(s1_data.pair.red_sum)   + ycc_pkg::SUM4_W'(above.red_sum);
   assign g4 = ycc_pkg::SUM4_W'(s1_data.pair.green_sum) + ycc_pkg::SUM4_W'(above.green_sum);
   assign b4 = ycc_pkg::SUM4_W'(s1_data.pair.blue_sum)  + ycc_pkg::SUM4_W'(above.blue_sum);

   // Coefficient products
   assign y_r  = ycc_pkg::YPROD_W'(ycc_pkg::Y_R_COEF) * ycc_pkg::YPROD_W'(s1_data.pixel.red);
   assign y_g  = ycc_pkg::YPROD_W'(ycc_pkg::Y_G_COEF) * ycc_pkg::YPROD_W'(s1_data.pixel.green);
   assign y_b  = ycc_pkg::YPROD_W'(ycc_pkg::Y_B_COEF) * ycc_pkg::YPROD_W'(s1_data.pixel.blue);
   assign cb_r = ycc_pkg::CPROD_W'(ycc_pkg::CB_R_COEF) * ycc_pkg::CPROD_W'(r4);
   assign cb_g = ycc_pkg::CPROD_W'(ycc_pkg::CB_G_COEF) * ycc_pkg::CPROD_W'(g4);
   assign cb_b = ycc_pkg::CPROD_W'(ycc_pkg::CB_B_COEF) * ycc_pkg::CPROD_W'(b4);
   assign cr_r = ycc_pkg::CPROD_W'(ycc_pkg::CR_R_COEF) * ycc_pkg::CPROD_W'(r4);
   assign cr_g = ycc_pkg::CPROD_W'(ycc_pkg::CR_G_COEF) * ycc_pkg::CPROD_W'(g4);
   assign cr_b = ycc_pkg::CPROD_W'(ycc_pkg::CR_B_COEF) * ycc_pkg::CPROD_W'(b4);

   // Sums in two's complement; the floor shift keeps the bits above the fraction
   assign luma_sum = y_r + y_g + y_b;
   assign cb_sum   = ycc_pkg::CSUM_W'(cb_b) - ycc_pkg::CSUM_W'(cb_r)
                     - ycc_pkg::CSUM_W'(cb_g);
   assign cr_sum   = ycc_pkg::CSUM_W'(cr_r) - ycc_pkg::CSUM_W'(cr_g)
                     - ycc_pkg::CSUM_W'(cr_b);

   always_comb begin
      out_in.luma         = luma_sum[ycc_pkg::FRAC_BITS +: ycc_pkg::PIX_W]
                            + ycc_pkg::PIX_W'(ycc_pkg::LUMA_OFFSET);
      out_in.chroma_valid = s1_data.chroma;
      out_in.blue_diff    = '0;
      out_in.red_diff     = '0;
      if (s1_data.chroma) begin
         out_in.blue_diff = cb_sum[ycc_pkg::FRAC_BITS +: ycc_pkg::PIX_W]
                            + ycc_pkg::PIX_W'(ycc_pkg::CHROMA_OFFSET);
         out_in.red_diff  = cr_sum[ycc_pkg::FRAC_BITS +: ycc_pkg::PIX_W]
                            + ycc_pkg::PIX_W'(ycc_pkg::CHROMA_OFFSET);
      end
   end

   assign out_valid_in = s2_free ? s1_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Load payload only when the front register advances
   always_ff @(posedge clock) begin
      if (s2_free && s1_valid) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.luma         = out_ff.luma;
   assign rsp_bus.chroma_valid = out_ff.chroma_valid;
   assign rsp_bus.blue_diff    = out_ff.blue_diff;
   assign rsp_bus.red_diff     = out_ff.red_diff;

   // A stalled response holds its contents
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("response lost while stalled");

   // Luma never drops below the studio black level
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.luma >= ycc_pkg::PIX_W'(ycc_pkg::LUMA_OFFSET)))
      else $error("luma below black level");

   // Chroma fields read zero on pixels that finish no block
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.chroma_valid)
         |-> (out_ff.blue_diff == '0 && out_ff.red_diff == '0))
      else $error("chroma set without a block");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the RGB to YCbCr 4:2:0 converter.
`timescale 1ns / 1ps

module testbench;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      ycc_pkg::pixel_type pixel;
      logic               frame_start;
      bit                 drain_first;
   } pending_type;

   localparam int SENDER_IDLE_PCT   = 46;
   localparam int RECEIVER_IDLE_PCT = 46;
   localparam int BOTH_IDLE_PCT     = 30;
   localparam int LONG_HOLD         = 150;
   localparam int DRAIN_CYCLES      = 8;
   localparam int REPORT_LIMIT      = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [ycc_pkg::CSR_AW-1:0] paddr;
   logic [ycc_pkg::CSR_DW-1:0] pwdata;
   logic [ycc_pkg::CSR_DW-1:0] prdata;
   logic                       pready;

   ycc_req_if req_if ();
   ycc_rsp_if rsp_if ();

   rgb_to_ycbcr420_converter DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if.sink),
      .rsp_bus (rsp_if.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Run-time state shared by the processes
   pending_type          pending_pixels[$];
   ycc_pkg::result_type  expected_results[$];
   idle_mode_type        idle_mode = IDLE_NONE;
   int                   mismatch_count = 0;
   int                   hold_requests = 0;
   int                   holds_begun = 0;
   int                   hold_left = 0;

   // Converter model state
   logic [ycc_pkg::LW_W-1:0] line_width_setting = ycc_pkg::LW_RESET;
   ycc_pkg::pair_sum_type    line_pairs [ycc_pkg::LINE_DEPTH];
   ycc_pkg::pixel_type       held_pixel = '0;
   int                       column_pos = 0;
   logic                     odd_row = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the converter model by one pixel and return its response
   function automatic ycc_pkg::result_type predict_pixel(ycc_pkg::pixel_type px,
                                                         logic new_frame);
      ycc_pkg::result_type   res;
      ycc_pkg::pair_sum_type pair;
      ycc_pkg::pair_sum_type above;
      int                    span;
      int                    idx;
      int                    r4;
      int                    g4;
      int                    b4;
      span = int'(line_width_setting & 12'hFFE);
      if (span < 2) span = 2;
      if (span > ycc_pkg::WIDTH_CAP) span = ycc_pkg::WIDTH_CAP;
      if (new_frame) begin
         column_pos = 0;
         odd_row = 1'b0;
      end
      res.luma = 8'(ycc_pkg::LUMA_OFFSET
                 + ((ycc_pkg::Y_R_COEF * int'(px.red) + ycc_pkg::Y_G_COEF * int'(px.green)
                 + ycc_pkg::Y_B_COEF * int'(px.blue)) >>> ycc_pkg::FRAC_BITS));
      res.chroma_valid = 1'b0;
      res.blue_diff = '0;
      res.red_diff = '0;
      idx = column_pos / 2;
      if (column_pos % 2 == 0) begin
         held_pixel = px;
      end else begin
         pair.red_sum   = {1'b0, held_pixel.red} + {1'b0, px.red};
         pair.green_sum = {1'b0, held_pixel.green} + {1'b0, px.green};
         pair.blue_sum  = {1'b0, held_pixel.blue} + {1'b0, px.blue};
         if (!odd_row) begin
            if (idx < ycc_pkg::LINE_DEPTH) line_pairs[idx] = pair;
         end else begin
            above = (idx < ycc_pkg::LINE_DEPTH) ? line_pairs[idx] : '0;
            r4 = int'(pair.red_sum) + int'(above.red_sum);
            g4 = int'(pair.green_sum) + int'(above.green_sum);
            b4 = int'(pair.blue_sum) + int'(above.blue_sum);
            res.blue_diff = 8'(ycc_pkg::CHROMA_OFFSET
                            + ((-ycc_pkg::CB_R_COEF * r4 - ycc_pkg::CB_G_COEF * g4
                            + ycc_pkg::CB_B_COEF * b4) >>> ycc_pkg::FRAC_BITS));
            res.red_diff  = 8'(ycc_pkg::CHROMA_OFFSET
                            + ((ycc_pkg::CR_R_COEF * r4 - ycc_pkg::CR_G_COEF * g4
                            - ycc_pkg::CR_B_COEF * b4) >>> ycc_pkg::FRAC_BITS));
            res.chroma_valid = 1'b1;
         end
      end
      if (column_pos + 1 >= span) begin
         column_pos = 0;
         odd_row = ~odd_row;
      end else begin
         column_pos++;
      end
      return res;
   endfunction

   // Drive pixel requests and predict each accepted one
   always @(posedge clock) begin : drive_pixels
      pending_type item;
      bit          idle;
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.red <= '0;
         req_if.green <= '0;
         req_if.blue <= '0;
         req_if.frame_start <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            expected_results.push_back(predict_pixel(
               '{blue: req_if.blue, green: req_if.green, red: req_if.red},
               req_if.frame_start));
         if (!req_if.valid || req_if.ready) begin
            idle = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < SENDER_IDLE_PCT)
                || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < BOTH_IDLE_PCT);
            if (pending_pixels.size() != 0 && !idle
                && !(pending_pixels[0].drain_first && expected_results.size() != 0)) begin
               item = pending_pixels.pop_front();
               req_if.valid <= 1'b1;
               req_if.red <= item.pixel.red;
               req_if.green <= item.pixel.green;
               req_if.blue <= item.pixel.blue;
               req_if.frame_start <= item.frame_start;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Hold off responses at random, or for a long stretch on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (holds_begun != hold_requests) begin
         holds_begun++;
         hold_left = LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !((idle_mode == IDLE_RECEIVER
                             && $urandom_range(0, 99) < RECEIVER_IDLE_PCT)
                          || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < BOTH_IDLE_PCT));
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_results
      ycc_pkg::result_type want;
      ycc_pkg::result_type got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.luma = rsp_if.luma;
         got.chroma_valid = rsp_if.chroma_valid;
         got.blue_diff = rsp_if.blue_diff;
         got.red_diff = rsp_if.red_diff;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected response: Y=%0d chroma=%0b Cb=%0d Cr=%0d",
                        got.luma, got.chroma_valid, got.blue_diff, got.red_diff);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"response mismatch: expected Y=%0d chroma=%0b Cb=%0d Cr=%0d,",
                            " got Y=%0d chroma=%0b Cb=%0d Cr=%0d"},
                           want.luma, want.chroma_valid, want.blue_diff, want.red_diff,
                           got.luma, got.chroma_valid, got.blue_diff, got.red_diff);
            end
         end
      end
   end

   // Bias channels toward the extremes
   function automatic logic [ycc_pkg::PIX_W-1:0] random_channel();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '1;
      if (pick == 1) return '0;
      return ycc_pkg::PIX_W'($urandom_range(0, 255));
   endfunction

   function automatic ycc_pkg::pixel_type random_pixel();
      ycc_pkg::pixel_type px;
      px.red = random_channel();
      px.green = random_channel();
      px.blue = random_channel();
      return px;
   endfunction

   task automatic queue_pixels(int count, bit new_frame, bit noisy, bit pause_midway);
      pending_type item;
      for (int i = 0; i < count; i++) begin
         item.pixel = random_pixel();
         item.frame_start = (new_frame && i == 0) || (noisy && $urandom_range(0, 199) == 0);
         item.drain_first = pause_midway && i == count / 2;
         pending_pixels.push_back(item);
      end
   endtask

   // Queue one uniform 2x2 block at a line width of two
   task automatic queue_block(logic [ycc_pkg::PIX_W-1:0] r, logic [ycc_pkg::PIX_W-1:0] g,
                              logic [ycc_pkg::PIX_W-1:0] b, bit new_frame);
      pending_type item;
      for (int i = 0; i < 4; i++) begin
         item.pixel = '{blue: b, green: g, red: r};
         item.frame_start = new_frame && i == 0;
         item.drain_first = 1'b0;
         pending_pixels.push_back(item);
      end
   endtask

   task automatic queue_pixel(logic [ycc_pkg::PIX_W-1:0] r, logic [ycc_pkg::PIX_W-1:0] g,
                              logic [ycc_pkg::PIX_W-1:0] b, bit new_frame);
      pending_type item;
      item.pixel = '{blue: b, green: g, red: r};
      item.frame_start = new_frame;
      item.drain_first = 1'b0;
      pending_pixels.push_back(item);
   endtask

   // Wait for every request to be answered, then let the pipeline settle
   task automatic wait_until_drained();
      @(negedge clock);
      while (pending_pixels.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_line_width(logic [ycc_pkg::LW_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ycc_pkg::ADDR_LINE_WIDTH;
      pwdata <= ycc_pkg::CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      line_width_setting = value;
   endtask

   task automatic run_phase(logic [ycc_pkg::LW_W-1:0] width, idle_mode_type mode, int count,
                            bit noisy, bit pause_midway);
      wait_until_drained();
      write_line_width(width);
      idle_mode = mode;
      queue_pixels(count, 1'b1, noisy, pause_midway);
   endtask

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : run_phases
      req_if.valid = 1'b0;
      req_if.red = '0;
      req_if.green = '0;
      req_if.blue = '0;
      req_if.frame_start = 1'b0;
      rsp_if.ready = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // One full row and part of the next at the reset width
      queue_pixels(650, 1'b1, 1'b0, 1'b0);

      // Uniform blocks at the color extremes, then back-to-back frame starts
      wait_until_drained();
      write_line_width(ycc_pkg::LW_W'(2));
      queue_block(8'd0, 8'd0, 8'd0, 1'b1);
      queue_block(8'd255, 8'd255, 8'd255, 1'b0);
      queue_block(8'd255, 8'd0, 8'd0, 1'b0);
      queue_block(8'd0, 8'd255, 8'd0, 1'b0);
      queue_block(8'd0, 8'd0, 8'd255, 1'b0);
      queue_pixel(8'd255, 8'd0, 8'd255, 1'b1);
      queue_pixel(8'd0, 8'd255, 8'd255, 1'b1);
      queue_pixel(8'd255, 8'd255, 8'd0, 1'b0);
      queue_pixel(8'd1, 8'd128, 8'd254, 1'b0);
      queue_pixel(8'd127, 8'd2, 8'd64, 1'b0);

      // Small widths, including ones below range and with bit 0 set
      run_phase(ycc_pkg::LW_W'(0), IDLE_SENDER, 100, 1'b1, 1'b0);
      run_phase(ycc_pkg::LW_W'(1), IDLE_RECEIVER, 60, 1'b1, 1'b1);
      run_phase(ycc_pkg::LW_W'(7), IDLE_BOTH, 100, 1'b1, 1'b0);

      // Shrink the width while the column lies beyond it
      run_phase(ycc_pkg::LW_W'(34), IDLE_SENDER, 20, 1'b0, 1'b0);
      wait_until_drained();
      write_line_width(ycc_pkg::LW_W'(6));
      queue_pixels(80, 1'b0, 1'b0, 1'b0);

      run_phase(ycc_pkg::LW_W'(10), IDLE_RECEIVER, 120, 1'b1, 1'b1);

      // Long response hold while requests keep coming, then a full drain midway
      run_phase(ycc_pkg::LW_W'(16), IDLE_NONE, 200, 1'b1, 1'b1);
      hold_requests++;

      // Width written above the cap
      run_phase(ycc_pkg::LW_W'(4095), IDLE_BOTH, 40, 1'b0, 1'b0);

      run_phase(ycc_pkg::LW_W'(130), IDLE_SENDER, 80, 1'b1, 1'b0);
      run_phase(ycc_pkg::LW_W'(3), IDLE_BOTH, 80, 1'b1, 1'b1);

      wait_until_drained();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/ycc_pkg.sv
sv/ycc_if.sv
sv/ycc_ram.sv
sv/ycc_csr.sv
sv/ycc_front.sv
sv/ycc_math.sv
sv/rgb_to_ycbcr420_converter.sv
tb/testbench.sv
